// File: rtl/assert_macros.svh
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every rising clock edge out of reset.
`define HRVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a property in the next.
`define HRVT_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// File: rtl/hrvt_pkg.sv
// Package: constants and types of the beat interval tracker.
`timescale 1ns / 1ps
package hrvt_pkg;
    localparam int RING_DEPTH    = 64;
    localparam int INTERVAL_BITS = 20;
    localparam int CFG_W         = 26;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_NUM_W     = 32;
    localparam int ROOT_W        = 16;
    localparam int ROOT_M_W      = 16;
    localparam int RATE_W        = 15;

    localparam logic [31:0] NN50_LIMIT        = 32'd500;
    localparam logic [31:0] TICKS_X10_PER_MIN = 32'd6000000;
    localparam logic [31:0] PERCENT           = 32'd100;
    localparam logic [14:0] RATE_MAX          = 15'h7fff;

    localparam logic [19:0] MIN_INTERVAL_RST = 20'd2500;
    localparam logic [19:0] MAX_INTERVAL_RST = 20'd20000;
    localparam logic [7:0]  REPORT_EVERY_RST = 8'd10;
    localparam logic [6:0]  MIN_STORED_RST   = 7'd10;
    localparam logic [25:0] MIN_WINDOW_RST   = 26'd600000;
    localparam logic [6:0]  RATE_WINDOW_RST  = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL = 3'd0,
        CFG_MAX_INTERVAL = 3'd1,
        CFG_REPORT_EVERY = 3'd2,
        CFG_MIN_STORED   = 3'd3,
        CFG_MIN_WINDOW   = 3'd4,
        CFG_RATE_WINDOW  = 3'd5,
        CFG_SOURCE_TAG   = 3'd6
    } t_cfg_idx;
endpackage

// File: rtl/beat_interval_hrv_tracker_unit.sv
// Top level: beat interval tracker with ring memory and report sequencer.
// Sequence: a beat that is not stored goes straight to the result; a stored beat first sums
// the k newest intervals for the rate and divides; a report adds a window walk and a pass
// over n intervals, then steps in the multiply, divide and root units, each shared by several.
// Throughput: one beat at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; no clearing pass, the fill count guards the ring.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module beat_interval_hrv_tracker_unit #(
    parameter int RING_DEPTH    = hrvt_pkg::RING_DEPTH,
    parameter int INTERVAL_BITS = hrvt_pkg::INTERVAL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hrvt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hrvt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_beat_time,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [14:0]                     o_rate_x10,
    output logic                            o_report_valid,
    output logic [14:0]                     o_report_rate_x10,
    output logic [15:0]                     o_sdnn,
    output logic [15:0]                     o_rmssd,
    output logic [6:0]                      o_pnn50,
    output logic [15:0]                     o_sd1,
    output logic [15:0]                     o_sd2,
    output logic [6:0]                      o_intervals_used,
    output logic [7:0]                      o_report_source
);
    localparam int IB = INTERVAL_BITS;
    localparam int NB = $clog2(RING_DEPTH + 1);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int SB = IB + NB;
    localparam int PB = 2 * IB + NB;
    localparam int AB = 2 * IB + 2 * NB + 2;
    localparam int NW = hrvt_pkg::DIV_NUM_W;
    localparam int MW = hrvt_pkg::ROOT_M_W;
    localparam logic [32:0] IV_MAX = (33'(1) << IB) - 33'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_RRD, S_RAC, S_WRD, S_WAC, S_PRD, S_PSQ, S_PES, S_PAC,
        S_OGO, S_OWT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_RATE, OP_NP, OP_SS, OP_CN, OP_RRATE, OP_PNN,
        OP_SDNN, OP_RMSSD, OP_SD1, OP_SD2
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [19:0] r_min_int;
    logic [19:0] r_max_int;
    logic [7:0]  r_rep_every;
    logic [6:0]  r_min_stored;
    logic [25:0] r_min_window;
    logic [6:0]  r_rate_window;
    logic [7:0]  r_src_tag;

    logic [31:0]   r_last;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_ptr;
    logic [NB-1:0] r_fill;
    logic [7:0]    r_bsr;
    logic          r_attempt;
    logic [NB-1:0] r_k;
    logic [NB-1:0] r_i;
    logic [NB-1:0] r_n;
    logic [NB-1:0] r_cnt;
    logic [SB-1:0] r_sum;
    logic [SB-1:0] r_span;
    logic [SB-1:0] r_s;
    logic [PB-1:0] r_p;
    logic [PB-1:0] r_c;
    logic [IB-1:0] r_x;
    logic [IB-1:0] r_prev;
    logic [IB-1:0] r_e;
    logic [2*IB-1:0] r_sq;
    logic [2*IB-1:0] r_esq;
    logic [AB-1:0] r_np;
    logic [AB-1:0] r_a;
    logic [AB-1:0] r_c2;

    logic        r_res_acc;
    logic [14:0] r_res_rate;
    logic        r_res_rvalid;
    logic [14:0] r_res_rrate;
    logic [15:0] r_res_sdnn;
    logic [15:0] r_res_rmssd;
    logic [6:0]  r_res_pnn;
    logic [15:0] r_res_sd1;
    logic [15:0] r_res_sd2;
    logic [6:0]  r_res_used;
    logic [7:0]  r_res_src;

    logic        r_out_valid;
    logic        r_o_acc;
    logic [14:0] r_o_rate;
    logic        r_o_rvalid;
    logic [14:0] r_o_rrate;
    logic [15:0] r_o_sdnn;
    logic [15:0] r_o_rmssd;
    logic [6:0]  r_o_pnn;
    logic [15:0] r_o_sd1;
    logic [15:0] r_o_sd2;
    logic [6:0]  r_o_used;
    logic [7:0]  r_o_src;

    logic          in_acc;
    logic [31:0]   iv;
    logic          re_arm;
    logic          store_ok;
    logic [NB-1:0] fill_n;
    logic [7:0]    bsr_n;
    logic [NB-1:0] k_n;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] ptr_dec;
    logic [IB-1:0] rdata;
    logic [SB-1:0] span_n;
    logic [NB-1:0] n_n;
    logic          span_ok;
    logic [NB-1:0] d;
    logic [2*NB-1:0] nd;
    logic [AB-1:0] a4;
    logic          slot_free;

    logic          op_skip;
    logic          op_go;
    logic          unit_done;
    logic          op_fin;
    logic          mul_start;
    logic          div_start;
    logic          root_start;
    logic          mul_done;
    logic          div_done;
    logic          root_done;
    logic [AB-1:0] mul_a;
    logic [SB-1:0] mul_b;
    logic [AB-1:0] mul_prod;
    logic [NW-1:0] div_num;
    logic [SB-1:0] div_den;
    logic [NW-1:0] div_q;
    logic [14:0]   div_sat;
    logic [AB-1:0] root_num;
    logic [MW-1:0] root_m;
    logic [15:0]   root_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign iv         = i_beat_time - r_last;
    assign re_arm     = (r_last == 32'd0) || (iv > 32'(r_max_int)) || ({1'b0, iv} > IV_MAX);
    assign store_ok   = !re_arm && !(iv < 32'(r_min_int));
    assign fill_n     = (r_fill == NB'(RING_DEPTH)) ? r_fill : r_fill + NB'(1);
    assign bsr_n      = r_bsr + 8'd1;
    assign k_n        = (8'(fill_n) < 8'(r_rate_window)) ? fill_n : NB'(r_rate_window);
    assign wp_inc     = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign ptr_dec    = (r_ptr == '0) ? AW'(RING_DEPTH - 1) : r_ptr - AW'(1);
    assign span_n     = r_span + SB'(rdata);
    assign n_n        = r_n + NB'(1);
    assign span_ok    = 64'(span_n) >= 64'(r_min_window);
    assign d          = r_n - NB'(1);
    assign nd         = (2*NB)'(r_n) * (2*NB)'(d);
    assign a4         = AB'({r_a, 2'b00});
    assign slot_free  = !r_out_valid || !i_out_stall;

    hrvt_ram #(.WIDTH(IB), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc && store_ok),
        .i_waddr (r_wp),
        .i_wdata (iv[IB-1:0]),
        .i_raddr (r_ptr),
        .o_rdata (rdata)
    );

    always_comb begin
        op_skip = 1'b0;
        case (r_op)
            OP_RATE:  op_skip = (r_k == '0) || (r_sum == '0);
            OP_RRATE: op_skip = (r_s == '0);
            OP_SD2:   op_skip = (a4 <= r_c2);
            default:  op_skip = 1'b0;
        endcase
    end

    always_comb begin
        mul_a    = AB'(r_p);
        mul_b    = SB'(r_n);
        div_num  = 32'(r_cnt) * hrvt_pkg::PERCENT;
        div_den  = SB'(d);
        root_num = a4 - r_c2;
        root_m   = MW'({nd, 1'b0});
        unit_done = root_done;
        case (r_op)
            OP_NP: begin
                unit_done = mul_done;
            end
            OP_SS: begin
                mul_a     = AB'(r_s);
                mul_b     = r_s;
                unit_done = mul_done;
            end
            OP_CN: begin
                mul_a     = AB'(r_c);
                unit_done = mul_done;
            end
            OP_RATE: begin
                div_num   = hrvt_pkg::TICKS_X10_PER_MIN * 32'(r_k);
                div_den   = r_sum;
                unit_done = div_done;
            end
            OP_RRATE: begin
                div_num   = hrvt_pkg::TICKS_X10_PER_MIN * 32'(r_n);
                div_den   = r_s;
                unit_done = div_done;
            end
            OP_PNN: begin
                unit_done = div_done;
            end
            OP_SDNN: begin
                root_num = r_a;
                root_m   = MW'(nd);
            end
            OP_RMSSD: begin
                root_num = AB'(r_c);
                root_m   = MW'(d);
            end
            OP_SD1: begin
                root_num = AB'(r_c);
                root_m   = MW'({d, 1'b0});
            end
            default: ;
        endcase
    end

    assign op_go      = (r_state == S_OGO) && !op_skip;
    assign mul_start  = op_go && (r_op == OP_NP || r_op == OP_SS || r_op == OP_CN);
    assign div_start  = op_go && (r_op == OP_RATE || r_op == OP_RRATE || r_op == OP_PNN);
    assign root_start = op_go && !mul_start && !div_start;
    assign op_fin     = ((r_state == S_OGO) && op_skip) || ((r_state == S_OWT) && unit_done);
    assign div_sat    = (div_q > 32'(hrvt_pkg::RATE_MAX)) ? hrvt_pkg::RATE_MAX : div_q[14:0];

    hrvt_mul #(.A_W(AB), .B_W(SB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    hrvt_div #(.DEN_W(SB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    hrvt_root #(.NUM_W(AB)) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_num   (root_num),
        .i_m     (root_m),
        .o_done  (root_done),
        .o_root  (root_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op          <= OP_RATE;
            r_last        <= '0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_bsr         <= '0;
            r_out_valid   <= 1'b0;
            r_min_int     <= hrvt_pkg::MIN_INTERVAL_RST;
            r_max_int     <= hrvt_pkg::MAX_INTERVAL_RST;
            r_rep_every   <= hrvt_pkg::REPORT_EVERY_RST;
            r_min_stored  <= hrvt_pkg::MIN_STORED_RST;
            r_min_window  <= hrvt_pkg::MIN_WINDOW_RST;
            r_rate_window <= hrvt_pkg::RATE_WINDOW_RST;
            r_src_tag     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hrvt_pkg::CFG_MIN_INTERVAL: r_min_int     <= i_cfg_data[19:0];
                    hrvt_pkg::CFG_MAX_INTERVAL: r_max_int     <= i_cfg_data[19:0];
                    hrvt_pkg::CFG_REPORT_EVERY: r_rep_every   <= i_cfg_data[7:0];
                    hrvt_pkg::CFG_MIN_STORED:   r_min_stored  <= i_cfg_data[6:0];
                    hrvt_pkg::CFG_MIN_WINDOW:   r_min_window  <= i_cfg_data[25:0];
                    hrvt_pkg::CFG_RATE_WINDOW:  r_rate_window <= i_cfg_data[6:0];
                    hrvt_pkg::CFG_SOURCE_TAG:   r_src_tag     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (op_fin) begin
                case (r_op)
                    OP_NP:    r_np        <= mul_prod;
                    OP_SS:    r_a         <= r_np - mul_prod;
                    OP_CN:    r_c2        <= mul_prod;
                    OP_RATE:  r_res_rate  <= (r_k == '0) ? 15'd0 :
                                             (r_sum == '0) ? hrvt_pkg::RATE_MAX : div_sat;
                    OP_RRATE: r_res_rrate <= (r_s == '0) ? hrvt_pkg::RATE_MAX : div_sat;
                    OP_PNN:   r_res_pnn   <= 7'(div_q);
                    OP_SDNN:  r_res_sdnn  <= root_res;
                    OP_RMSSD: r_res_rmssd <= root_res;
                    OP_SD1:   r_res_sd1   <= root_res;
                    default:  r_res_sd2   <= op_skip ? 16'd0 : root_res;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_acc    <= store_ok;
                        r_res_rate   <= '0;
                        r_res_rvalid <= 1'b0;
                        r_res_rrate  <= '0;
                        r_res_sdnn   <= '0;
                        r_res_rmssd  <= '0;
                        r_res_pnn    <= '0;
                        r_res_sd1    <= '0;
                        r_res_sd2    <= '0;
                        r_res_used   <= '0;
                        r_res_src    <= '0;
                        if (re_arm) begin
                            r_last  <= i_beat_time;
                            r_state <= S_DONE;
                        end else if (store_ok) begin
                            r_last    <= i_beat_time;
                            r_head    <= r_wp;
                            r_ptr     <= r_wp;
                            r_wp      <= wp_inc;
                            r_fill    <= fill_n;
                            r_k       <= k_n;
                            r_i       <= '0;
                            r_sum     <= '0;
                            r_op      <= OP_RATE;
                            if (bsr_n >= r_rep_every) begin
                                r_bsr     <= '0;
                                r_attempt <= 8'(fill_n) >= 8'(r_min_stored);
                            end else begin
                                r_bsr     <= bsr_n;
                                r_attempt <= 1'b0;
                            end
                            r_state <= (k_n == '0) ? S_OGO : S_RRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RRD: r_state <= S_RAC;
                S_RAC: begin
                    r_sum <= r_sum + SB'(rdata);
                    r_i   <= r_i + NB'(1);
                    r_ptr <= ptr_dec;
                    r_state <= ((r_i + NB'(1)) == r_k) ? S_OGO : S_RRD;
                end
                S_WRD: r_state <= S_WAC;
                S_WAC: begin
                    r_span <= span_n;
                    r_n    <= n_n;
                    if (span_ok || ((r_i + NB'(1)) == r_fill)) begin
                        r_i   <= '0;
                        r_ptr <= r_head;
                        if (!span_ok || (n_n < NB'(2))) begin
                            r_state <= S_DONE;
                        end else begin
                            r_s     <= '0;
                            r_p     <= '0;
                            r_c     <= '0;
                            r_cnt   <= '0;
                            r_state <= S_PRD;
                        end
                    end else begin
                        r_i     <= r_i + NB'(1);
                        r_ptr   <= ptr_dec;
                        r_state <= S_WRD;
                    end
                end
                S_PRD: r_state <= S_PSQ;
                S_PSQ: begin
                    r_x     <= rdata;
                    r_sq    <= (2*IB)'(rdata) * (2*IB)'(rdata);
                    r_e     <= (r_prev > rdata) ? r_prev - rdata : rdata - r_prev;
                    r_state <= S_PES;
                end
                S_PES: begin
                    r_esq   <= (2*IB)'(r_e) * (2*IB)'(r_e);
                    r_s     <= r_s + SB'(r_x);
                    r_p     <= r_p + PB'(r_sq);
                    r_prev  <= r_x;
                    r_state <= S_PAC;
                end
                S_PAC: begin
                    if (r_i != '0) begin
                        r_c <= r_c + PB'(r_esq);
                        if (32'(r_e) > hrvt_pkg::NN50_LIMIT) begin
                            r_cnt <= r_cnt + NB'(1);
                        end
                    end
                    r_i   <= r_i + NB'(1);
                    r_ptr <= ptr_dec;
                    if ((r_i + NB'(1)) == r_n) begin
                        r_op    <= OP_NP;
                        r_state <= S_OGO;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                S_OGO, S_OWT: begin
                    if (r_state == S_OGO && !op_skip) begin
                        r_state <= S_OWT;
                    end
                    if (op_fin) begin
                        case (r_op)
                            OP_RATE: begin
                                r_i    <= '0;
                                r_ptr  <= r_head;
                                r_span <= '0;
                                r_n    <= '0;
                                r_state <= r_attempt ? S_WRD : S_DONE;
                            end
                            OP_NP:    begin r_op <= OP_SS;    r_state <= S_OGO; end
                            OP_SS:    begin r_op <= OP_CN;    r_state <= S_OGO; end
                            OP_CN:    begin r_op <= OP_RRATE; r_state <= S_OGO; end
                            OP_RRATE: begin r_op <= OP_PNN;   r_state <= S_OGO; end
                            OP_PNN:   begin r_op <= OP_SDNN;  r_state <= S_OGO; end
                            OP_SDNN:  begin r_op <= OP_RMSSD; r_state <= S_OGO; end
                            OP_RMSSD: begin r_op <= OP_SD1;   r_state <= S_OGO; end
                            OP_SD1:   begin r_op <= OP_SD2;   r_state <= S_OGO; end
                            default: begin
                                r_res_rvalid <= 1'b1;
                                r_res_used   <= 7'(r_n);
                                r_res_src    <= r_src_tag;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_o_acc     <= r_res_acc;
                        r_o_rate    <= r_res_rate;
                        r_o_rvalid  <= r_res_rvalid;
                        r_o_rrate   <= r_res_rrate;
                        r_o_sdnn    <= r_res_sdnn;
                        r_o_rmssd   <= r_res_rmssd;
                        r_o_pnn     <= r_res_pnn;
                        r_o_sd1     <= r_res_sd1;
                        r_o_sd2     <= r_res_sd2;
                        r_o_used    <= r_res_used;
                        r_o_src     <= r_res_src;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_o_acc;
    assign o_rate_x10        = r_o_rate;
    assign o_report_valid    = r_o_rvalid;
    assign o_report_rate_x10 = r_o_rrate;
    assign o_sdnn            = r_o_sdnn;
    assign o_rmssd           = r_o_rmssd;
    assign o_pnn50           = r_o_pnn;
    assign o_sd1             = r_o_sd1;
    assign o_sd2             = r_o_sd2;
    assign o_intervals_used  = r_o_used;
    assign o_report_source   = r_o_src;

    `HRVT_ASSERT(a_fill_bound, r_fill <= NB'(RING_DEPTH), "fill count beyond ring depth")
    `HRVT_ASSERT(a_report_n, (op_fin && r_op == OP_SD2) |-> (r_n >= NB'(2)), "report with n < 2")
    `HRVT_ASSERT_NEXT(a_hold_out, (r_state == S_DONE && r_out_valid && i_out_stall), $stable(o_sdnn) && $stable(o_accepted), "result overwritten while stalled")
endmodule

// File: rtl/hrvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module hrvt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/hrvt_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module hrvt_mul #(
    parameter int A_W = 82,
    parameter int B_W = 39
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [A_W-1:0] o_prod
);
    localparam int CW = $clog2(B_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [A_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[A_W-2:0], 1'b0};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(B_W);
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// File: rtl/hrvt_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hrvt_div #(
    parameter int DEN_W = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hrvt_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic                          o_done,
    output logic [hrvt_pkg::DIV_NUM_W-1:0] o_quot
);
    localparam int NW = hrvt_pkg::DIV_NUM_W;
    localparam int CW = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NW-1:0]    r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_q[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                r_q   <= {r_q[NW-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: rtl/hrvt_root.sv
// Bitwise search for the largest s with s*s*m <= num; each bit takes a square, multiply and compare step.
`timescale 1ns / 1ps
module hrvt_root #(
    parameter int NUM_W = 82
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [hrvt_pkg::ROOT_M_W-1:0] i_m,
    output logic                         o_done,
    output logic [hrvt_pkg::ROOT_W-1:0]   o_root
);
    localparam int RW = hrvt_pkg::ROOT_W;
    localparam int MW = hrvt_pkg::ROOT_M_W;
    localparam int PW = 2 * RW + MW;
    localparam int CW = (NUM_W > PW) ? NUM_W : PW;

    typedef enum logic [1:0] {PH_IDLE, PH_SQ, PH_MUL, PH_CMP} t_ph;

    t_ph             r_ph;
    logic            r_done;
    logic [RW-1:0]   r_s;
    logic [RW-1:0]   r_bit;
    logic [2*RW-1:0] r_sq;
    logic [PW-1:0]   r_prod;
    logic [NUM_W-1:0] r_num;
    logic [MW-1:0]   r_m;
    logic [RW-1:0]   cand;

    assign cand = r_s | r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_num <= i_num;
                        r_m   <= i_m;
                        r_s   <= '0;
                        r_bit <= {1'b1, {(RW-1){1'b0}}};
                        r_ph  <= PH_SQ;
                    end
                end
                PH_SQ: begin
                    r_sq <= (2*RW)'(cand) * (2*RW)'(cand);
                    r_ph <= PH_MUL;
                end
                PH_MUL: begin
                    r_prod <= PW'(r_sq) * PW'(r_m);
                    r_ph   <= PH_CMP;
                end
                PH_CMP: begin
                    if (CW'(r_prod) <= CW'(r_num)) begin
                        r_s <= cand;
                    end
                    r_bit <= r_bit >> 1;
                    if (r_bit[0]) begin
                        r_ph   <= PH_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_ph <= PH_SQ;
                    end
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_s;
endmodule

// File: tb/hrvt_checker.sv
// Checker: predicts tracker results from observed transactions and compares them.
`timescale 1ns / 1ps
module hrvt_checker
    import hrvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [31:0]          i_beat_time,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_accepted,
    input  logic [14:0]          i_rate_x10,
    input  logic                 i_report_valid,
    input  logic [14:0]          i_report_rate_x10,
    input  logic [15:0]          i_sdnn,
    input  logic [15:0]          i_rmssd,
    input  logic [6:0]           i_pnn50,
    input  logic [15:0]          i_sd1,
    input  logic [15:0]          i_sd2,
    input  logic [6:0]           i_intervals_used,
    input  logic [7:0]           i_report_source,
    output int                   o_fail_count,
    output int                   o_pending
);
    typedef struct {
        logic        accepted;
        logic [14:0] rate_x10;
        logic        report_valid;
        logic [14:0] report_rate_x10;
        logic [15:0] sdnn;
        logic [15:0] rmssd;
        logic [6:0]  pnn50;
        logic [15:0] sd1;
        logic [15:0] sd2;
        logic [6:0]  intervals_used;
        logic [7:0]  report_source;
    } beat_result_t;

    beat_result_t expected_results[$];

    logic [19:0] ring [RING_DEPTH];
    logic [31:0] last_time;
    logic [5:0]  wr_ptr;
    logic [6:0]  fill;
    logic [7:0]  beats_since;
    logic [19:0] min_iv, max_iv;
    logic [7:0]  report_every;
    logic [6:0]  min_stored;
    logic [25:0] min_window;
    logic [6:0]  rate_window;
    logic [7:0]  source_tag;

    function automatic logic [14:0] rate_of(logic [63:0] n, logic [63:0] sum);
        logic [63:0] q;
        if (sum == 0) return RATE_MAX;
        q = (64'(TICKS_X10_PER_MIN) * n) / sum;
        return (q > 64'(RATE_MAX)) ? RATE_MAX : q[14:0];
    endfunction

    function automatic logic [15:0] root_ratio(logic [127:0] num, logic [127:0] m);
        logic [15:0] s;
        logic [15:0] c;
        s = '0;
        for (int b = 15; b >= 0; b--) begin
            c = s | (16'd1 << b);
            if (128'(c) * 128'(c) * m <= num) s = c;
        end
        return s;
    endfunction

    function automatic logic [63:0] ring_back(int i);
        logic [5:0] idx;
        idx = wr_ptr - 6'd1 - 6'(i);
        return 64'(ring[idx]);
    endfunction

    task automatic try_report(inout beat_result_t r);
        logic [63:0]  span, s, n, d, cnt, x, y, e;
        logic [127:0] p, c, a, n2, c2;
        span = 0; s = 0; n = 0; cnt = 0; p = 0; c = 0;
        if (fill < min_stored) return;
        for (int i = 0; i < fill; i++) begin
            span += ring_back(i);
            n++;
            if (span >= 64'(min_window)) break;
        end
        if (span < 64'(min_window) || n < 2) return;
        for (int i = 0; i < n; i++) begin
            x = ring_back(i);
            s += x;
            p += 128'(x) * 128'(x);
        end
        for (int i = 0; i + 1 < n; i++) begin
            x = ring_back(i);
            y = ring_back(i + 1);
            e = (x > y) ? x - y : y - x;
            c += 128'(e) * 128'(e);
            if (e > 64'(NN50_LIMIT)) cnt++;
        end
        d = n - 1;
        a = p * 128'(n) - 128'(s) * 128'(s);
        r.report_valid    = 1'b1;
        r.report_rate_x10 = rate_of(n, s);
        r.sdnn            = root_ratio(a, 128'(n * d));
        r.rmssd           = root_ratio(c, 128'(d));
        r.pnn50           = 7'((cnt * 64'(PERCENT)) / d);
        r.sd1             = root_ratio(c, 128'(2 * d));
        n2 = a * 4;
        c2 = c * 128'(n);
        r.sd2             = (n2 <= c2) ? 16'd0 : root_ratio(n2 - c2, 128'(2 * n * d));
        r.intervals_used  = n[6:0];
        r.report_source   = source_tag;
    endtask

    task automatic predict_beat(input logic [31:0] t, output beat_result_t r);
        logic [31:0] iv;
        logic [6:0]  k;
        logic [63:0] sum;
        r = '{default: '0};
        sum = 0;
        if (last_time == 0) begin
            last_time = t;
            return;
        end
        iv = t - last_time;
        if (iv > 32'(max_iv) || iv > 32'((1 << INTERVAL_BITS) - 1)) begin
            last_time = t;
            return;
        end
        if (iv < 32'(min_iv)) return;
        last_time = t;
        ring[wr_ptr] = iv[19:0];
        wr_ptr = wr_ptr + 6'd1;
        if (fill < RING_DEPTH) fill = fill + 7'd1;
        r.accepted = 1'b1;
        beats_since = beats_since + 8'd1;
        if (beats_since >= report_every) begin
            try_report(r);
            beats_since = '0;
        end
        k = (fill < rate_window) ? fill : rate_window;
        for (int i = 0; i < k; i++) sum += ring_back(i);
        if (k > 0) r.rate_x10 = rate_of(64'(k), sum);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        beat_result_t r;
        beat_result_t e;
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
            last_time    = '0;
            wr_ptr       = '0;
            fill         = '0;
            beats_since  = '0;
            min_iv       = MIN_INTERVAL_RST;
            max_iv       = MAX_INTERVAL_RST;
            report_every = REPORT_EVERY_RST;
            min_stored   = MIN_STORED_RST;
            min_window   = MIN_WINDOW_RST;
            rate_window  = RATE_WINDOW_RST;
            source_tag   = '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MIN_INTERVAL: min_iv       = i_cfg_data[19:0];
                    CFG_MAX_INTERVAL: max_iv       = i_cfg_data[19:0];
                    CFG_REPORT_EVERY: report_every = i_cfg_data[7:0];
                    CFG_MIN_STORED:   min_stored   = i_cfg_data[6:0];
                    CFG_MIN_WINDOW:   min_window   = i_cfg_data[25:0];
                    CFG_RATE_WINDOW:  rate_window  = i_cfg_data[6:0];
                    CFG_SOURCE_TAG:   source_tag   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expected result");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("accepted", e.accepted, i_accepted);
                    check_field("rate_x10", e.rate_x10, i_rate_x10);
                    check_field("report_valid", e.report_valid, i_report_valid);
                    check_field("report_rate_x10", e.report_rate_x10, i_report_rate_x10);
                    check_field("sdnn", e.sdnn, i_sdnn);
                    check_field("rmssd", e.rmssd, i_rmssd);
                    check_field("pnn50", e.pnn50, i_pnn50);
                    check_field("sd1", e.sd1, i_sd1);
                    check_field("sd2", e.sd2, i_sd2);
                    check_field("intervals_used", e.intervals_used, i_intervals_used);
                    check_field("report_source", e.report_source, i_report_source);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_beat_time, r);
                expected_results.push_back(r);
            end
            o_pending = expected_results.size();
        end
    end
endmodule

// File: tb/tb_beat_interval_hrv_tracker_unit.sv
// Testbench top: clock, reset, beat and configuration stimulus, and the verdict.
`timescale 1ns / 1ps
module tb_beat_interval_hrv_tracker_unit;
    import hrvt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int END_WAIT       = 2000;
    localparam int PHASE_ITEMS    = 190;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [31:0]          i_beat_time = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_accepted, o_report_valid;
    logic [14:0]          o_rate_x10, o_report_rate_x10;
    logic [15:0]          o_sdnn, o_rmssd, o_sd1, o_sd2;
    logic [6:0]           o_pnn50, o_intervals_used;
    logic [7:0]           o_report_source;
    int                   fail_count, pending;

    int          idle_mode = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] anchor = '0;
    logic [19:0] cur_min = MIN_INTERVAL_RST;
    logic [19:0] cur_max = MAX_INTERVAL_RST;

    beat_interval_hrv_tracker_unit dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_beat_time,
        .o_out_valid, .i_out_stall,
        .o_accepted, .o_rate_x10, .o_report_valid, .o_report_rate_x10,
        .o_sdnn, .o_rmssd, .o_pnn50, .o_sd1, .o_sd2,
        .o_intervals_used, .o_report_source
    );

    hrvt_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_beat_time,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_accepted(o_accepted), .i_rate_x10(o_rate_x10),
        .i_report_valid(o_report_valid), .i_report_rate_x10(o_report_rate_x10),
        .i_sdnn(o_sdnn), .i_rmssd(o_rmssd), .i_pnn50(o_pnn50),
        .i_sd1(o_sd1), .i_sd2(o_sd2), .i_intervals_used(o_intervals_used),
        .i_report_source(o_report_source),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else if (idle_mode == 2) begin
            i_out_stall = ($urandom_range(0, 99) < 71);
        end else if (idle_mode == 3) begin
            i_out_stall = ($urandom_range(0, 99) < 30);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_beat_interval_hrv_tracker_unit failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [31:0] t);
        int idle_pct;
        idle_pct = (idle_mode == 1) ? 71 : (idle_mode == 3) ? 30 : 0;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_beat_time = t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_MIN_INTERVAL) cur_min = v[19:0];
        if (idx == CFG_MAX_INTERVAL) cur_max = v[19:0];
    endtask

    task automatic configure(input logic [19:0] mn, input logic [19:0] mx,
                             input logic [7:0] rep, input logic [6:0] stored,
                             input logic [25:0] win, input logic [6:0] rwin,
                             input logic [7:0] tag);
        drain();
        write_reg(CFG_MIN_INTERVAL, CFG_W'(mn));
        write_reg(CFG_MAX_INTERVAL, CFG_W'(mx));
        write_reg(CFG_REPORT_EVERY, CFG_W'(rep));
        write_reg(CFG_MIN_STORED, CFG_W'(stored));
        write_reg(CFG_MIN_WINDOW, win);
        write_reg(CFG_RATE_WINDOW, CFG_W'(rwin));
        write_reg(CFG_SOURCE_TAG, CFG_W'(tag));
    endtask

    task automatic random_config();
        logic [19:0] mn;
        mn = 20'($urandom_range(0, 4000));
        configure(mn, mn + 20'($urandom_range(500, 40000)), 8'($urandom_range(0, 12)),
                  7'($urandom_range(1, 20)), 26'($urandom_range(0, 150000)),
                  7'($urandom_range(0, 70)), 8'($urandom));
    endtask

    task automatic random_beat();
        int          pick;
        logic [31:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            t = anchor + 32'($urandom_range(cur_min, cur_max));
            anchor = t;
        end else if (pick < 88) begin
            t = anchor + ((cur_min == 0) ? 32'd0 : 32'($urandom_range(0, cur_min - 1)));
        end else if (pick < 93) begin
            t = anchor + 32'(cur_max) + 32'($urandom_range(1, 100000));
            anchor = t;
        end else if (pick < 96) begin
            t = '0;
            anchor = '0;
        end else begin
            t = $urandom;
            anchor = t;
        end
        send_beat(t);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: zero time, re-arm, store, short, long, wrap
        send_beat(32'd0);
        send_beat(32'd1000);
        send_beat(32'd4000);
        send_beat(32'd4100);
        send_beat(32'd50000);
        send_beat(32'hFFFF_F000);
        send_beat(32'h0000_0F00);
        send_beat(32'hFFFF_FFFF);

        configure(20'd0, 20'hFFFFF, 8'd1, 7'd2, 26'd4000, 7'd64, 8'hFF);
        send_beat(32'd1000);
        send_beat(32'd1000);
        send_beat(32'd1000 + 32'hFFFFF);
        send_beat(32'd1000 + 32'hFFFFF + 32'h100000);
        send_beat(32'd3000000);
        send_beat(32'd3000600);
        send_beat(32'd3000700);
        send_beat(32'd3001800);

        configure(20'hFFFFF, 20'hFFFFF, 8'd0, 7'd64, 26'h3FFFFFF, 7'd0, 8'd0);
        send_beat(32'd5000);
        send_beat(32'd5000 + 32'hFFFFF);
        send_beat(32'd5005);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: configure(20'd2500, 20'd20000, 8'd5, 7'd4, 26'd20000, 7'd8, 8'($urandom));
                3: configure(20'd0, 20'hFFFFF, 8'd0, 7'd2, 26'($urandom_range(0, 3000000)),
                             7'($urandom_range(1, 64)), 8'($urandom));
                4: configure(20'($urandom_range(0, 3000)), 20'($urandom_range(20000, 60000)),
                             8'd255, 7'(($urandom_range(0, 1) != 0) ? 64 : 127),
                             26'($urandom), 7'd64, 8'($urandom));
                default: random_config();
            endcase
            idle_mode = ph % 4;
            anchor = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 40) hold_seq++;
                if (ph == 2 && n == 120) drain();
                random_beat();
            end
        end

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_beat_interval_hrv_tracker_unit passed");
        else
            $display("tb_beat_interval_hrv_tracker_unit failed");
        $finish;
    end
endmodule

// File: beat_interval_hrv_tracker_unit.f
+incdir+rtl
rtl/hrvt_pkg.sv
rtl/hrvt_ram.sv
rtl/hrvt_mul.sv
rtl/hrvt_div.sv
rtl/hrvt_root.sv
rtl/beat_interval_hrv_tracker_unit.sv
tb/hrvt_checker.sv
tb/tb_beat_interval_hrv_tracker_unit.sv
